[design/vaau_pkg.sv]
// Package for the vector angle and unit vector block.
// Holds the transfer payload types, fixed-point widths and the arc cosine coefficients.
// Depends on nothing.
package vaau_pkg;

  localparam int CoordW       = 32;
  localparam int UnitFracBits = 15;
  localparam int UnitW        = UnitFracBits + 1;
  localparam int AngleW       = 18;
  localparam int MagW         = 30;
  localparam int QW           = 31;
  localparam int SqInW        = 64;
  localparam int SqRootW      = 32;
  localparam int DivQW        = 32;
  localparam int TW           = 33;
  localparam int UnitSh       = 30 - UnitFracBits;

  localparam logic [QW-1:0]     QOne     = QW'(1) << 30;
  localparam logic [31:0]       PiQ30    = 32'd3373259426;
  localparam logic [AngleW-1:0] AngleMax = AngleW'(205887);
  localparam logic [QW:0]       UnitFull = (QW + 1)'(1) << UnitFracBits;
  localparam logic [QW:0]       UnitHalf = (UnitSh > 0) ? ((QW + 1)'(1) << (UnitSh - 1)) :
                                                           (QW + 1)'(0);

  typedef struct packed {
    logic signed [CoordW-1:0] sat_x;
    logic signed [CoordW-1:0] sat_y;
    logic signed [CoordW-1:0] sat_z;
    logic signed [CoordW-1:0] sun_x;
    logic signed [CoordW-1:0] sun_y;
    logic signed [CoordW-1:0] sun_z;
  } vaau_in_t;

  typedef struct packed {
    logic        [AngleW-1:0] angle;
    logic signed [UnitW-1:0]  unit_a_x;
    logic signed [UnitW-1:0]  unit_a_y;
    logic signed [UnitW-1:0]  unit_a_z;
    logic signed [UnitW-1:0]  unit_b_x;
    logic signed [UnitW-1:0]  unit_b_y;
    logic signed [UnitW-1:0]  unit_b_z;
    logic                     zero_vector;
  } vaau_out_t;

  // Normalised magnitudes: entries 0 to 2 are the first vector, 3 to 5 the second.
  typedef struct packed {
    logic [5:0][MagW-1:0] mag;
    logic [5:0]           neg;
    logic                 zero;
  } vec_side_t;

  typedef struct packed {
    logic signed [TW-1:0]  t;
    logic                  cneg;
    logic [5:0][UnitW-1:0] unit;
    logic                  zero;
  } ang_side_t;

  localparam int SqSideW = ($bits(vec_side_t) > $bits(ang_side_t)) ? $bits(vec_side_t) :
                                                                      $bits(ang_side_t);

  function automatic logic signed [TW-1:0] acos_coef(input logic [2:0] k);
    logic signed [TW-1:0] c;
    case (k)
      3'd0:    c = 33'sd1686629690;
      3'd1:    c = -33'sd230423709;
      3'd2:    c = 33'sd95540460;
      3'd3:    c = -33'sd53874249;
      3'd4:    c = 33'sd33169905;
      3'd5:    c = -33'sd18348235;
      3'd6:    c = 33'sd7161955;
      default: c = -33'sd1355589;
    endcase
    return c;
  endfunction

endpackage

[design/vaau_prep.sv]
// Input stages: magnitudes, block normalisation, squares and sums of squares.
// Three register stages. Depends on vaau_pkg.
module vaau_prep import vaau_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  vaau_in_t                   data_i,
  output logic                       valid_o,
  output logic [1:0][SqInW-1:0]      sum_o,
  output vec_side_t                  side_o
);

  localparam int PosW  = $clog2(CoordW);
  localparam int WideW = CoordW + MagW - 1;

  logic [5:0][CoordW-1:0] raw;
  logic [5:0][CoordW-1:0] mag_abs;
  logic [1:0][CoordW-1:0] orv;
  logic [1:0][PosW-1:0]   pos;
  logic [5:0][WideW-1:0]  wide;
  vec_side_t              side1_d, side1_q, side2_q, side3_q;
  logic [5:0][2*MagW-1:0] sq_d, sq_q;
  logic [1:0][SqInW-1:0]  sum_d, sum_q;
  logic                   v1_q, v2_q, v3_q;

  assign raw = {data_i.sun_z, data_i.sun_y, data_i.sun_x,
                data_i.sat_z, data_i.sat_y, data_i.sat_x};

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      mag_abs[i] = raw[i][CoordW-1] ? (~raw[i] + 1'b1) : raw[i];
    end
    for (int v = 0; v < 2; v++) begin
      orv[v] = mag_abs[3*v] | mag_abs[3*v+1] | mag_abs[3*v+2];
      pos[v] = '0;
      for (int b = 0; b < CoordW; b++) begin
        if (orv[v][b]) pos[v] = PosW'(b);
      end
    end
    for (int i = 0; i < 6; i++) begin
      wide[i]          = {mag_abs[i], (MagW - 1)'(0)} >> pos[i/3];
      side1_d.mag[i]   = wide[i][MagW-1:0];
      side1_d.neg[i]   = raw[i][CoordW-1];
    end
    side1_d.zero = (orv[0] == '0) || (orv[1] == '0);
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      sq_d[i] = side1_q.mag[i] * side1_q.mag[i];
    end
    for (int v = 0; v < 2; v++) begin
      sum_d[v] = SqInW'(sq_q[3*v]) + SqInW'(sq_q[3*v+1]) + SqInW'(sq_q[3*v+2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side1_d;
      side2_q <= side1_q;
      side3_q <= side2_q;
      sq_q    <= sq_d;
      sum_q   <= sum_d;
    end
  end

  assign valid_o = v3_q;
  assign sum_o   = sum_q;
  assign side_o  = side3_q;

endmodule

[design/vaau_isqrt.sv]
// Pipelined integer square root, two result bits per register stage.
// Carries a side word alongside the radicand. Depends on vaau_pkg.
module vaau_isqrt import vaau_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [SqInW-1:0]   rad_i,
  input  logic [SqSideW-1:0] side_i,
  output logic               valid_o,
  output logic [SqRootW-1:0] root_o,
  output logic [SqSideW-1:0] side_o
);

  localparam int NSt  = SqRootW / 2;
  localparam int RemW = SqRootW + 2;

  logic               v_q    [NSt];
  logic [RemW-1:0]    rem_q  [NSt];
  logic [SqRootW-1:0] root_q [NSt];
  logic [SqInW-1:0]   rad_q  [NSt];
  logic [SqSideW-1:0] side_q [NSt];

  for (genvar s = 0; s < NSt; s++) begin : g_stage
    logic               v_in;
    logic [RemW-1:0]    rem_in, rem_d;
    logic [SqRootW-1:0] root_in, root_d;
    logic [SqInW-1:0]   rad_in, rad_d;
    logic [SqSideW-1:0] side_in;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_rest
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      logic [RemW+1:0] trial;
      logic [RemW+1:0] test;
      logic [RemW+1:0] diff;
      rem_d  = rem_in;
      root_d = root_in;
      rad_d  = rad_in;
      for (int k = 0; k < 2; k++) begin
        trial = {rem_d, rad_d[SqInW-1 -: 2]};
        test  = (RemW + 2)'({root_d, 2'b01});
        diff  = trial - test;
        rad_d = rad_d << 2;
        if (trial >= test) begin
          rem_d  = diff[RemW-1:0];
          root_d = {root_d[SqRootW-2:0], 1'b1};
        end else begin
          rem_d  = trial[RemW-1:0];
          root_d = {root_d[SqRootW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        rad_q[s]  <= rad_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NSt-1];
  assign root_o  = root_q[NSt-1];
  assign side_o  = side_q[NSt-1];

endmodule

[design/vaau_div.sv]
// Pipelined rounded division of the six normalised magnitudes by their vector norm.
// Restoring division, two quotient bits per stage. Depends on vaau_pkg.
module vaau_div import vaau_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [1:0][SqRootW-1:0]   n_i,
  input  vec_side_t                 side_i,
  output logic                      valid_o,
  output logic [5:0][DivQW-1:0]     q_o,
  output logic [5:0]                neg_o,
  output logic                      zero_o
);

  localparam int NSt = DivQW / 2;

  logic                    v_q    [NSt];
  logic [1:0][SqRootW-1:0] n_q    [NSt];
  logic [5:0][31:0]        rem_q  [NSt];
  logic [5:0][31:0]        low_q  [NSt];
  logic [5:0][DivQW-1:0]   quo_q  [NSt];
  logic [5:0]              neg_q  [NSt];
  logic                    zero_q [NSt];

  logic [5:0][63:0] dvd;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      dvd[i] = {4'b0, side_i.mag[i], 30'b0} + 64'(n_i[i/3] >> 1);
    end
  end

  for (genvar s = 0; s < NSt; s++) begin : g_stage
    logic                    v_in, zero_in;
    logic [1:0][SqRootW-1:0] n_in;
    logic [5:0][31:0]        rem_in, rem_d, low_in, low_d;
    logic [5:0][DivQW-1:0]   quo_in, quo_d;
    logic [5:0]              neg_in;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign n_in    = n_i;
      assign quo_in  = '0;
      assign neg_in  = side_i.neg;
      assign zero_in = side_i.zero;
      for (genvar i = 0; i < 6; i++) begin : g_lane
        assign rem_in[i] = dvd[i][63:32];
        assign low_in[i] = dvd[i][31:0];
      end
    end else begin : g_rest
      assign v_in    = v_q[s-1];
      assign n_in    = n_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign low_in  = low_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign neg_in  = neg_q[s-1];
      assign zero_in = zero_q[s-1];
    end

    always_comb begin
      logic [32:0] r2;
      rem_d = rem_in;
      low_d = low_in;
      quo_d = quo_in;
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < 6; i++) begin
          r2       = {rem_d[i], low_d[i][31]};
          low_d[i] = low_d[i] << 1;
          if (r2 >= {1'b0, n_in[i/3]}) begin
            r2       = r2 - {1'b0, n_in[i/3]};
            quo_d[i] = {quo_d[i][DivQW-2:0], 1'b1};
          end else begin
            quo_d[i] = {quo_d[i][DivQW-2:0], 1'b0};
          end
          rem_d[i] = r2[31:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s]    <= n_in;
        rem_q[s]  <= rem_d;
        low_q[s]  <= low_d;
        quo_q[s]  <= quo_d;
        neg_q[s]  <= neg_in;
        zero_q[s] <= zero_in;
      end
    end
  end

  assign valid_o = v_q[NSt-1];
  assign q_o     = quo_q[NSt-1];
  assign neg_o   = neg_q[NSt-1];
  assign zero_o  = zero_q[NSt-1];

endmodule

[design/vaau_acos.sv]
// Unit outputs, cosine, polynomial arc cosine, its square root factor and the final angle.
// Depends on vaau_pkg and vaau_isqrt.
module vaau_acos import vaau_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [5:0][DivQW-1:0] q_i,
  input  logic [5:0]            neg_i,
  input  logic                  zero_i,
  output logic                  valid_o,
  output vaau_out_t             data_o
);

  localparam int NH = 7;

  function automatic logic signed [TW-1:0] mulq(input logic signed [TW-1:0] a,
                                                input logic [31:0] b);
    logic [TW-2:0] ma;
    logic [63:0]   p;
    logic [TW-1:0] pm;
    ma = a[TW-1] ? (~a[TW-2:0] + 1'b1) : a[TW-2:0];
    p  = ma * b;
    p  = (p + 64'(QOne >> 1)) >> 30;
    pm = p[TW-1:0];
    return a[TW-1] ? -$signed(pm) : $signed(pm);
  endfunction

  function automatic logic [UnitW-1:0] to_unit(input logic [QW-1:0] u, input logic neg);
    logic [QW:0]      v;
    logic [UnitW-1:0] r;
    v = ({1'b0, u} + UnitHalf) >> UnitSh;
    if (!neg) begin
      r = (v > UnitFull - 1'b1) ? UnitW'(UnitFull - 1'b1) : UnitW'(v);
    end else begin
      if (v > UnitFull) v = UnitFull;
      r = UnitW'(~v + 1'b1);
    end
    return r;
  endfunction

  // Unit conversion and component products.
  logic [5:0][QW-1:0]    u;
  logic [5:0][UnitW-1:0] unit_d, unit1_q, unit2_q;
  logic [2:0][2*QW-1:0]  prod_d, prod_q;
  logic [2:0]            pneg_d, pneg_q;
  logic                  v1_q, zero1_q;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      u[i]      = (q_i[i] > DivQW'(QOne)) ? QOne : q_i[i][QW-1:0];
      unit_d[i] = to_unit(u[i], neg_i[i]);
    end
    for (int j = 0; j < 3; j++) begin
      prod_d[j] = u[j] * u[j+3];
      pneg_d[j] = neg_i[j] ^ neg_i[j+3];
    end
  end

  // Cosine in Q30.
  logic signed [63:0] dot;
  logic [63:0]        dmag, dround;
  logic [QW-1:0]      x_d, x2_q;
  logic               cneg_d, cneg2_q, v2_q, zero2_q;

  always_comb begin
    dot = '0;
    for (int j = 0; j < 3; j++) begin
      if (pneg_q[j]) dot = dot - $signed({2'b0, prod_q[j]});
      else           dot = dot + $signed({2'b0, prod_q[j]});
    end
    cneg_d = dot[63];
    dmag   = cneg_d ? (~dot + 1'b1) : dot;
    dround = (dmag + 64'(QOne >> 1)) >> 30;
    x_d    = (dround > 64'(QOne)) ? QOne : dround[QW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unit1_q <= unit_d;
      prod_q  <= prod_d;
      pneg_q  <= pneg_d;
      zero1_q <= zero_i;
      unit2_q <= unit1_q;
      x2_q    <= x_d;
      cneg2_q <= cneg_d;
      zero2_q <= zero1_q;
    end
  end

  // Horner evaluation of the polynomial, one coefficient per stage.
  logic          hv_q [NH];
  ang_side_t     hs_q [NH];
  logic [QW-1:0] hx_q [NH];

  for (genvar h = 0; h < NH; h++) begin : g_horner
    logic          v_in;
    ang_side_t     s_in, s_d;
    logic [QW-1:0] x_in;

    if (h == 0) begin : g_first
      assign v_in      = v2_q;
      assign x_in      = x2_q;
      assign s_in.t    = acos_coef(3'd7);
      assign s_in.cneg = cneg2_q;
      assign s_in.unit = unit2_q;
      assign s_in.zero = zero2_q;
    end else begin : g_rest
      assign v_in = hv_q[h-1];
      assign x_in = hx_q[h-1];
      assign s_in = hs_q[h-1];
    end

    always_comb begin
      s_d   = s_in;
      s_d.t = mulq(s_in.t, 32'(x_in)) + acos_coef(3'(NH - 1 - h));
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hv_q[h] <= 1'b0;
      end else if (en_i) begin
        hv_q[h] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        hs_q[h] <= s_d;
        hx_q[h] <= x_in;
      end
    end
  end

  // Square root of one minus the cosine magnitude.
  logic [SqInW-1:0]   rad;
  logic               sq_valid;
  logic [SqRootW-1:0] sq_root;
  logic [SqSideW-1:0] sq_side;
  ang_side_t          as;

  assign rad = {3'b0, QOne - hx_q[NH-1], 30'b0};

  vaau_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (hv_q[NH-1]),
    .rad_i   (rad),
    .side_i  (SqSideW'(hs_q[NH-1])),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  assign as = sq_side[$bits(ang_side_t)-1:0];

  // Final product, then quadrant fold, rounding and cap on the way out.
  logic signed [TW-1:0] p_d;
  logic [31:0]          a30_d, a30_q;
  ang_side_t            f_q;
  logic                 vf_q;

  always_comb begin
    p_d   = mulq(as.t, sq_root);
    a30_d = p_d[TW-1] ? 32'd0 : p_d[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a30_q <= a30_d;
      f_q   <= as;
    end
  end

  logic [31:0]       afold;
  logic [32:0]       around;
  logic [AngleW-1:0] angle;

  always_comb begin
    if (f_q.cneg) afold = (a30_q > PiQ30) ? 32'd0 : (PiQ30 - a30_q);
    else          afold = a30_q;
    around = (33'(afold) + 33'(1 << 13)) >> 14;
    angle  = (around > 33'(AngleMax)) ? AngleMax : around[AngleW-1:0];
    if (f_q.zero) begin
      data_o             = '0;
      data_o.zero_vector = 1'b1;
    end else begin
      data_o.angle       = angle;
      data_o.unit_a_x    = f_q.unit[0];
      data_o.unit_a_y    = f_q.unit[1];
      data_o.unit_a_z    = f_q.unit[2];
      data_o.unit_b_x    = f_q.unit[3];
      data_o.unit_b_y    = f_q.unit[4];
      data_o.unit_b_z    = f_q.unit[5];
      data_o.zero_vector = 1'b0;
    end
  end

  assign valid_o = vf_q;

endmodule

[design/vector_angle_and_unit_vectors.sv]
// Angle between two signed 3D vectors and the unit vector of each.
// Top level: pipeline sections and the output skid stage. Depends on vaau_pkg,
// vaau_prep, vaau_isqrt, vaau_div and vaau_acos.
//
// Usage:
// The input channel carries one vector pair per transfer (in_valid_i, in_stall_o,
// in_data_i); the output channel carries one result per transfer (out_valid_o,
// out_stall_i, out_data_o). Each input transfer gives exactly one result, in order.
// The block takes one vector pair in every cycle while in_stall_o is low. The path
// of a result runs through the two 16-stage square root pipelines, the 16-stage
// divider and the seven Horner stages, besides the prep and output registers.
// Reset empties every stage; nothing else is kept between items.
// When the receiver stalls, the output register holds its result and one more
// result is caught in the skid register; the input is then stalled and the whole
// pipeline holds until the output transfer completes.
module vector_angle_and_unit_vectors import vaau_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  vaau_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output vaau_out_t out_data_o
);

  logic                    en;
  logic                    prep_valid;
  logic [1:0][SqInW-1:0]   prep_sum;
  vec_side_t               prep_side;
  logic                    sqa_valid;
  logic [1:0][SqRootW-1:0] norm;
  logic [SqSideW-1:0]      sqa_side;
  logic                    div_valid;
  logic [5:0][DivQW-1:0]   div_q;
  logic [5:0]              div_neg;
  logic                    div_zero;
  logic                    pipe_valid;
  vaau_out_t               pipe_data;

  logic      out_valid_q, skid_valid_q, take;
  vaau_out_t out_q, skid_q;

  assign en = !skid_valid_q;

  vaau_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (prep_valid),
    .sum_o   (prep_sum),
    .side_o  (prep_side)
  );

  vaau_isqrt u_isqrt_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_valid),
    .rad_i   (prep_sum[0]),
    .side_i  (SqSideW'(prep_side)),
    .valid_o (sqa_valid),
    .root_o  (norm[0]),
    .side_o  (sqa_side)
  );

  vaau_isqrt u_isqrt_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_valid),
    .rad_i   (prep_sum[1]),
    .side_i  ('0),
    .valid_o (),
    .root_o  (norm[1]),
    .side_o  ()
  );

  vaau_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqa_valid),
    .n_i     (norm),
    .side_i  (sqa_side[$bits(vec_side_t)-1:0]),
    .valid_o (div_valid),
    .q_o     (div_q),
    .neg_o   (div_neg),
    .zero_o  (div_zero)
  );

  vaau_acos u_acos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .q_i     (div_q),
    .neg_i   (div_neg),
    .zero_i  (div_zero),
    .valid_o (pipe_valid),
    .data_o  (pipe_data)
  );

  assign take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || take) begin
      out_valid_q <= pipe_valid;
    end else if (pipe_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) out_q <= skid_q;
    end else if (!out_valid_q || take) begin
      out_q <= pipe_data;
    end else begin
      skid_q <= pipe_data;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[design/vaau_checker.sv]
// Port-level checks for the vector angle block, bound to its top level.
// Depends on vaau_pkg and vector_angle_and_unit_vectors.
module vaau_checker import vaau_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_i,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input vaau_out_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("Stalled result changed or vanished.");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.zero_vector |->
      out_data_i.angle == '0 && out_data_i.unit_a_x == '0 && out_data_i.unit_a_y == '0 &&
      out_data_i.unit_a_z == '0 && out_data_i.unit_b_x == '0 &&
      out_data_i.unit_b_y == '0 && out_data_i.unit_b_z == '0)
    else $error("Zero vector result carries non-zero fields.");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.angle <= AngleMax)
    else $error("Angle above pi.");

  a_skid_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |-> out_valid_i)
    else $error("Input stalled with no result held.");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i && out_valid_i && !out_stall_i |=> !in_stall_i)
    else $error("Input still stalled after an output transfer.");

endmodule

bind vector_angle_and_unit_vectors vaau_checker u_vaau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
